// ----- hdl/snfc_pkg.sv -----
// Shared types, codes and the result script decoder of the flash command sequencer.
`timescale 1ns / 1ps
package snfc_pkg;

    localparam int ID_BYTES_DEF   = 3;
    localparam int PAGE_BYTES     = 256;
    localparam int QUEUE_DEPTH    = 4;
    localparam int ADDR_W         = 24;
    localparam int LEN_W          = 16;
    localparam int CHUNK_W        = 9;
    localparam int STEP_W         = 4;

    localparam logic [2:0] OP_READ_ID = 3'd0;
    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_PROGRAM = 3'd2;
    localparam logic [2:0] OP_SECTOR  = 3'd3;
    localparam logic [2:0] OP_CHIP    = 3'd4;
    localparam logic [2:0] OP_DATA    = 3'd5;
    localparam logic [2:0] OP_REPLY   = 3'd6;

    localparam logic [7:0] CMD_READ_ID = 8'h9F;
    localparam logic [7:0] CMD_PROGRAM = 8'h02;
    localparam logic [7:0] CMD_READ    = 8'h03;
    localparam logic [7:0] CMD_STATUS  = 8'h05;
    localparam logic [7:0] CMD_WREN    = 8'h06;
    localparam logic [7:0] CMD_SECTOR  = 8'h20;
    localparam logic [7:0] CMD_CHIP    = 8'hC7;
    localparam logic [7:0] BUSY_MASK   = 8'h01;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 9'd8;
    localparam logic [CHUNK_W-1:0] CHUNK_MAX   = 9'd256;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ID_RX, PH_RD_RX, PH_ER_PRE, PH_ER_POST, PH_PG_DATA, PH_PG_POLL
    } phase_t;

    typedef enum logic [2:0] {
        ACT_SEL, ACT_SEND, ACT_RECV, ACT_DESEL, ACT_HOST, ACT_DONE, ACT_REJECT
    } action_t;

    typedef enum logic [3:0] {
        S_REJECT, S_ID_START, S_RD_START, S_RD_EMPTY, S_DONE, S_CHUNK, S_POLL_CHUNK,
        S_ERASE, S_HOST_RECV, S_HOST_END, S_RECV, S_SECTOR, S_CHIP, S_DESEL_DONE,
        S_PG_BYTE, S_PG_LAST
    } script_t;

    typedef struct packed {
        script_t           script;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } record_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] value;
        logic       last;
    } step_t;

    function automatic step_t mk(action_t a, logic [7:0] v, logic l);
        step_t s;
        s.action = a;
        s.value  = v;
        s.last   = l;
        return s;
    endfunction

    // Bytes in the next program command: chunk size clamped, then bytes left, then page room.
    function automatic logic [CHUNK_W-1:0] chunk_len(logic [CHUNK_W-1:0] cs,
                                                     logic [LEN_W-1:0] left,
                                                     logic [ADDR_W-1:0] addr);
        logic [CHUNK_W-1:0] c;
        logic [CHUNK_W-1:0] room;
        c = cs;
        if (c == '0) c = 9'd1;
        if (c > CHUNK_MAX) c = CHUNK_MAX;
        if (LEN_W'(c) > left) c = left[CHUNK_W-1:0];
        room = CHUNK_W'(PAGE_BYTES) - {1'b0, addr[7:0]};
        if (c > room) c = room;
        return c;
    endfunction

    function automatic step_t chunk_step(logic [STEP_W-1:0] i, logic [ADDR_W-1:0] a);
        step_t s;
        s = mk(ACT_REJECT, 8'h00, 1'b1);
        unique case (i)
            4'd0: s = mk(ACT_SEL, 8'h00, 1'b0);
            4'd1: s = mk(ACT_SEND, CMD_WREN, 1'b0);
            4'd2: s = mk(ACT_DESEL, 8'h00, 1'b0);
            4'd3: s = mk(ACT_SEL, 8'h00, 1'b0);
            4'd4: s = mk(ACT_SEND, CMD_PROGRAM, 1'b0);
            4'd5: s = mk(ACT_SEND, a[23:16], 1'b0);
            4'd6: s = mk(ACT_SEND, a[15:8], 1'b0);
            4'd7: s = mk(ACT_SEND, a[7:0], 1'b1);
            default: s = mk(ACT_REJECT, 8'h00, 1'b1);
        endcase
        return s;
    endfunction

    function automatic step_t script_step(record_t r, logic [STEP_W-1:0] i);
        step_t s;
        s = mk(ACT_REJECT, 8'h00, 1'b1);
        unique case (r.script)
            S_REJECT, S_DONE, S_RECV, S_PG_BYTE: begin
                unique case (r.script)
                    S_DONE:    s = mk(ACT_DONE, 8'h00, 1'b1);
                    S_RECV:    s = mk(ACT_RECV, 8'h00, 1'b1);
                    S_PG_BYTE: s = mk(ACT_SEND, r.data, 1'b1);
                    default:   s = mk(ACT_REJECT, 8'h00, 1'b1);
                endcase
            end
            S_ID_START: begin
                unique case (i)
                    4'd0:    s = mk(ACT_SEL, 8'h00, 1'b0);
                    4'd1:    s = mk(ACT_SEND, CMD_READ_ID, 1'b0);
                    default: s = mk(ACT_RECV, 8'h00, 1'b1);
                endcase
            end
            S_RD_START, S_RD_EMPTY: begin
                unique case (i)
                    4'd0: s = mk(ACT_SEL, 8'h00, 1'b0);
                    4'd1: s = mk(ACT_SEND, CMD_READ, 1'b0);
                    4'd2: s = mk(ACT_SEND, r.addr[23:16], 1'b0);
                    4'd3: s = mk(ACT_SEND, r.addr[15:8], 1'b0);
                    4'd4: s = mk(ACT_SEND, r.addr[7:0], 1'b0);
                    4'd5: s = (r.script == S_RD_START) ? mk(ACT_RECV, 8'h00, 1'b1)
                                                       : mk(ACT_DESEL, 8'h00, 1'b0);
                    default: s = mk(ACT_DONE, 8'h00, 1'b1);
                endcase
            end
            S_CHUNK: s = chunk_step(i, r.addr);
            S_POLL_CHUNK: begin
                if (i == '0) s = mk(ACT_DESEL, 8'h00, 1'b0);
                else s = chunk_step(i - 4'd1, r.addr);
            end
            S_ERASE: begin
                unique case (i)
                    4'd0: s = mk(ACT_SEL, 8'h00, 1'b0);
                    4'd1: s = mk(ACT_SEND, CMD_WREN, 1'b0);
                    4'd2: s = mk(ACT_DESEL, 8'h00, 1'b0);
                    4'd3: s = mk(ACT_SEL, 8'h00, 1'b0);
                    4'd4: s = mk(ACT_SEND, CMD_STATUS, 1'b0);
                    default: s = mk(ACT_RECV, 8'h00, 1'b1);
                endcase
            end
            S_HOST_RECV: begin
                if (i == '0) s = mk(ACT_HOST, r.data, 1'b0);
                else s = mk(ACT_RECV, 8'h00, 1'b1);
            end
            S_HOST_END: begin
                unique case (i)
                    4'd0:    s = mk(ACT_HOST, r.data, 1'b0);
                    4'd1:    s = mk(ACT_DESEL, 8'h00, 1'b0);
                    default: s = mk(ACT_DONE, 8'h00, 1'b1);
                endcase
            end
            S_SECTOR: begin
                unique case (i)
                    4'd0: s = mk(ACT_DESEL, 8'h00, 1'b0);
                    4'd1: s = mk(ACT_SEL, 8'h00, 1'b0);
                    4'd2: s = mk(ACT_SEND, CMD_SECTOR, 1'b0);
                    4'd3: s = mk(ACT_SEND, r.addr[23:16], 1'b0);
                    4'd4: s = mk(ACT_SEND, r.addr[15:8], 1'b0);
                    4'd5: s = mk(ACT_SEND, r.addr[7:0], 1'b0);
                    4'd6: s = mk(ACT_DESEL, 8'h00, 1'b0);
                    4'd7: s = mk(ACT_SEL, 8'h00, 1'b0);
                    4'd8: s = mk(ACT_SEND, CMD_STATUS, 1'b0);
                    default: s = mk(ACT_RECV, 8'h00, 1'b1);
                endcase
            end
            S_CHIP: begin
                unique case (i)
                    4'd0: s = mk(ACT_DESEL, 8'h00, 1'b0);
                    4'd1: s = mk(ACT_SEL, 8'h00, 1'b0);
                    4'd2: s = mk(ACT_SEND, CMD_CHIP, 1'b0);
                    4'd3: s = mk(ACT_DESEL, 8'h00, 1'b0);
                    4'd4: s = mk(ACT_SEL, 8'h00, 1'b0);
                    4'd5: s = mk(ACT_SEND, CMD_STATUS, 1'b0);
                    default: s = mk(ACT_RECV, 8'h00, 1'b1);
                endcase
            end
            S_DESEL_DONE: begin
                if (i == '0) s = mk(ACT_DESEL, 8'h00, 1'b0);
                else s = mk(ACT_DONE, 8'h00, 1'b1);
            end
            S_PG_LAST: begin
                unique case (i)
                    4'd0: s = mk(ACT_SEND, r.data, 1'b0);
                    4'd1: s = mk(ACT_DESEL, 8'h00, 1'b0);
                    4'd2: s = mk(ACT_SEL, 8'h00, 1'b0);
                    4'd3: s = mk(ACT_SEND, CMD_STATUS, 1'b0);
                    default: s = mk(ACT_RECV, 8'h00, 1'b1);
                endcase
            end
            default: s = mk(ACT_REJECT, 8'h00, 1'b1);
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/spi_nor_flash_command_sequencer_core.sv -----
// Top level of the serial NOR flash command sequencer.
`timescale 1ns / 1ps
// Byte-level host side of a serial NOR flash link. Push request, program data and
// flash reply words; pop bus actions and host events. Each accepted word is
// decided combinationally by the front end, which updates the transaction state
// and queues a short script; the back end expands the script into result words
// at one word per cycle unless the receiver holds the output. A word yields 1 to
// 10 results, and the input is held off only while the four-entry queue is full.
// Program commands never cross a 256-byte page. Requests while busy, data or
// replies not expected, and unknown operations each yield a single reject.
module spi_nor_flash_command_sequencer_core #(
    parameter int ID_BYTES = snfc_pkg::ID_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [2:0]                    operation,
    input  logic [snfc_pkg::ADDR_W-1:0]   address,
    input  logic [snfc_pkg::LEN_W-1:0]    length,
    input  logic [7:0]                    data_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [2:0]                    action,
    output logic [7:0]                    byte_value,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [snfc_pkg::CHUNK_W-1:0]  cfg_data
);

    localparam int RW = $bits(snfc_pkg::record_t);

    snfc_pkg::record_t rec_in, rec_out;
    logic [RW-1:0]     rec_bits;
    logic              take, q_empty, q_pop;

    // Take a word only when the queue has room for its script.
    assign take = push && !full;

    snfc_front #(.ID_BYTES(ID_BYTES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .operation (operation),
        .address   (address),
        .length    (length),
        .data_byte (data_byte),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .rec       (rec_in)
    );

    snfc_fifo #(.WIDTH(RW), .DEPTH(snfc_pkg::QUEUE_DEPTH)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (rec_in),
        .rd_en   (q_pop),
        .rd_data (rec_bits),
        .full    (full),
        .empty   (q_empty)
    );

    assign rec_out = snfc_pkg::record_t'(rec_bits);

    // Drain the queue head step by step; release it on its final step.
    snfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec        (rec_out),
        .rec_valid  (!q_empty),
        .rec_pop    (q_pop),
        .action     (action),
        .byte_value (byte_value),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// ----- hdl/snfc_front.sv -----
// Front end: accept words, track the transaction state and pick a result script.
`timescale 1ns / 1ps
module snfc_front #(
    parameter int ID_BYTES = snfc_pkg::ID_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic [2:0]                          operation,
    input  logic [snfc_pkg::ADDR_W-1:0]         address,
    input  logic [snfc_pkg::LEN_W-1:0]          length,
    input  logic [7:0]                          data_byte,
    input  logic                                cfg_we,
    input  logic [snfc_pkg::CHUNK_W-1:0]        cfg_data,
    output snfc_pkg::record_t                   rec
);

    snfc_pkg::phase_t                   phase_reg, phase_next;
    logic [2:0]                         req_reg, req_next;
    logic [snfc_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    logic [snfc_pkg::LEN_W-1:0]         left_reg, left_next;
    logic [snfc_pkg::CHUNK_W-1:0]       chunk_reg, chunk_next;
    logic [1:0]                         id_reg, id_next;
    logic [snfc_pkg::CHUNK_W-1:0]       size_reg;
    logic [2:0]                         id_inc;
    logic [snfc_pkg::LEN_W-1:0]         left_dec;
    logic [snfc_pkg::CHUNK_W-1:0]       chunk_dec;
    logic                               busy;

    assign id_inc    = {1'b0, id_reg} + 3'd1;
    assign left_dec  = left_reg - 16'd1;
    assign chunk_dec = chunk_reg - 9'd1;
    assign busy      = (data_byte & snfc_pkg::BUSY_MASK) != 8'h00;

    always_comb
    begin
        phase_next = phase_reg;
        req_next   = req_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        chunk_next = chunk_reg;
        id_next    = id_reg;
        rec.script = snfc_pkg::S_REJECT;
        rec.addr   = addr_reg;
        rec.data   = data_byte;
        if (operation <= snfc_pkg::OP_CHIP) begin
            if (phase_reg == snfc_pkg::PH_IDLE) begin
                req_next  = operation;
                addr_next = address;
                rec.addr  = address;
                unique case (operation)
                    snfc_pkg::OP_READ_ID: begin
                        id_next    = 2'd0;
                        rec.script = snfc_pkg::S_ID_START;
                        phase_next = snfc_pkg::PH_ID_RX;
                    end
                    snfc_pkg::OP_READ: begin
                        left_next = length;
                        if (length == '0) begin
                            rec.script = snfc_pkg::S_RD_EMPTY;
                        end else begin
                            rec.script = snfc_pkg::S_RD_START;
                            phase_next = snfc_pkg::PH_RD_RX;
                        end
                    end
                    snfc_pkg::OP_PROGRAM: begin
                        left_next = length;
                        if (length == '0) begin
                            rec.script = snfc_pkg::S_DONE;
                        end else begin
                            chunk_next = snfc_pkg::chunk_len(size_reg, length, address);
                            rec.script = snfc_pkg::S_CHUNK;
                            phase_next = snfc_pkg::PH_PG_DATA;
                        end
                    end
                    default: begin
                        rec.script = snfc_pkg::S_ERASE;
                        phase_next = snfc_pkg::PH_ER_PRE;
                    end
                endcase
            end
        end else if (operation == snfc_pkg::OP_DATA) begin
            if (phase_reg == snfc_pkg::PH_PG_DATA) begin
                addr_next  = addr_reg + 24'd1;
                left_next  = left_dec;
                chunk_next = chunk_dec;
                if (chunk_dec == '0) begin
                    rec.script = snfc_pkg::S_PG_LAST;
                    phase_next = snfc_pkg::PH_PG_POLL;
                end else begin
                    rec.script = snfc_pkg::S_PG_BYTE;
                end
            end
        end else if (operation == snfc_pkg::OP_REPLY) begin
            unique case (phase_reg)
                snfc_pkg::PH_ID_RX: begin
                    id_next = id_inc[1:0];
                    if (id_inc >= 3'(ID_BYTES)) begin
                        rec.script = snfc_pkg::S_HOST_END;
                        phase_next = snfc_pkg::PH_IDLE;
                    end else begin
                        rec.script = snfc_pkg::S_HOST_RECV;
                    end
                end
                snfc_pkg::PH_RD_RX: begin
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        rec.script = snfc_pkg::S_HOST_END;
                        phase_next = snfc_pkg::PH_IDLE;
                    end else begin
                        rec.script = snfc_pkg::S_HOST_RECV;
                    end
                end
                snfc_pkg::PH_ER_PRE: begin
                    if (busy) begin
                        rec.script = snfc_pkg::S_RECV;
                    end else begin
                        rec.script = (req_reg == snfc_pkg::OP_SECTOR) ? snfc_pkg::S_SECTOR
                                                                      : snfc_pkg::S_CHIP;
                        phase_next = snfc_pkg::PH_ER_POST;
                    end
                end
                snfc_pkg::PH_ER_POST: begin
                    if (busy) begin
                        rec.script = snfc_pkg::S_RECV;
                    end else begin
                        rec.script = snfc_pkg::S_DESEL_DONE;
                        phase_next = snfc_pkg::PH_IDLE;
                    end
                end
                snfc_pkg::PH_PG_POLL: begin
                    if (busy) begin
                        rec.script = snfc_pkg::S_RECV;
                    end else if (left_reg == '0) begin
                        rec.script = snfc_pkg::S_DESEL_DONE;
                        phase_next = snfc_pkg::PH_IDLE;
                    end else begin
                        chunk_next = snfc_pkg::chunk_len(size_reg, left_reg, addr_reg);
                        rec.script = snfc_pkg::S_POLL_CHUNK;
                        phase_next = snfc_pkg::PH_PG_DATA;
                    end
                end
                default: rec.script = snfc_pkg::S_REJECT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= snfc_pkg::PH_IDLE;
            req_reg   <= '0;
            addr_reg  <= '0;
            left_reg  <= '0;
            chunk_reg <= '0;
            id_reg    <= '0;
            size_reg  <= snfc_pkg::CHUNK_RESET;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                req_reg   <= req_next;
                addr_reg  <= addr_next;
                left_reg  <= left_next;
                chunk_reg <= chunk_next;
                id_reg    <= id_next;
            end
            if (cfg_we) begin
                size_reg <= cfg_data;
            end
        end
    end

endmodule

// ----- hdl/snfc_fifo.sv -----
// Small register queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module snfc_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = snfc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [CW-1:0]    cnt_reg;

    assign full    = cnt_reg == CW'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_data = mem_reg[rp_reg];

    function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= bump(wp_reg);
            if (rd_en) rp_reg <= bump(rp_reg);
            cnt_reg <= cnt_reg + CW'(wr_en) - CW'(rd_en);
        end
    end

endmodule

// ----- hdl/snfc_back.sv -----
// Back end: queued scripts become results, one per cycle unless held.
`timescale 1ns / 1ps
module snfc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  snfc_pkg::record_t rec,
    input  logic              rec_valid,
    output logic              rec_pop,
    output logic [2:0]        action,
    output logic [7:0]        byte_value,
    output logic              last,
    output logic              empty,
    input  logic              pop
);

    logic [snfc_pkg::STEP_W-1:0] idx_reg;
    logic                        valid_reg;
    snfc_pkg::step_t             out_reg, cur;
    logic                        advance;

    assign cur        = snfc_pkg::script_step(rec, idx_reg);
    assign advance    = rec_valid && (!valid_reg || pop);
    assign rec_pop    = advance && cur.last;
    assign empty      = !valid_reg;
    assign action     = out_reg.action;
    assign byte_value = out_reg.value;
    assign last       = out_reg.last;

    always_ff @(posedge clk)
    begin
        if (advance) out_reg <= cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                idx_reg   <= cur.last ? '0 : idx_reg + 1'b1;
                valid_reg <= 1'b1;
            end else if (pop) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench of the serial NOR flash command sequencer.
`timescale 1ns / 1ps
// Words are pushed as request, program data and flash reply sequences. Each sequence
// is built to follow the flash protocol, with its busy polls, chunk splits and page
// crossings worked out ahead. Noise words that must be rejected are mixed in. A
// predictor follows each accepted word and queues the bus actions and host events
// it expects. The monitor pops results and checks each field against the oldest
// expectation. Both sides idle at random. The receiver holds off once so that the
// queue fills up. The chunk size is changed between phases, while the block is idle.
module testbench;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int STALE_LIMIT = 3000;

    typedef struct {
        logic [2:0]  op;
        logic [23:0] addr;
        logic [15:0] len;
        logic [7:0]  b;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic [2:0] operation = '0;
    logic [23:0] address = '0;
    logic [15:0] length = '0;
    logic [7:0] data_byte = '0;
    logic [2:0] action;
    logic [7:0] byte_value;
    logic last;
    logic cfg_we = 1'b0;
    logic [8:0] cfg_data = '0;

    word_t pending[$];
    word_t offered;
    snfc_pkg::step_t bus_expect[$];
    int errors = 0;
    int words_taken = 0;
    int results_taken = 0;
    int phase_words = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int stale = 0;

    // Predictor state
    snfc_pkg::phase_t seq_ph = snfc_pkg::PH_IDLE;
    logic [2:0] seq_req = '0;
    logic [23:0] seq_addr = '0;
    logic [15:0] seq_left = '0;
    logic [8:0] seq_chunk = '0;
    logic [1:0] seq_ids = '0;
    logic [8:0] chunk_size = 9'd8;

    always #5 clk = ~clk;

    spi_nor_flash_command_sequencer_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .address(address), .length(length), .data_byte(data_byte),
        .empty(empty), .pop(pop), .action(action), .byte_value(byte_value), .last(last),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    function automatic int bytes_in_chunk(logic [8:0] cs, logic [15:0] left, logic [23:0] a);
        int c;
        int room;
        c = cs;
        room = 256 - a[7:0];
        if (c == 0) c = 1;
        if (c > 256) c = 256;
        if (c > left) c = left;
        if (c > room) c = room;
        return c;
    endfunction

    task automatic put(snfc_pkg::action_t a, logic [7:0] v);
        snfc_pkg::step_t s;
        s.action = a;
        s.value  = v;
        s.last   = 1'b0;
        bus_expect.push_back(s);
    endtask

    task automatic put_addr(logic [23:0] a);
        put(snfc_pkg::ACT_SEND, a[23:16]);
        put(snfc_pkg::ACT_SEND, a[15:8]);
        put(snfc_pkg::ACT_SEND, a[7:0]);
    endtask

    task automatic put_poll();
        put(snfc_pkg::ACT_SEL, 8'h00);
        put(snfc_pkg::ACT_SEND, snfc_pkg::CMD_STATUS);
        put(snfc_pkg::ACT_RECV, 8'h00);
    endtask

    task automatic put_wren();
        put(snfc_pkg::ACT_SEL, 8'h00);
        put(snfc_pkg::ACT_SEND, snfc_pkg::CMD_WREN);
        put(snfc_pkg::ACT_DESEL, 8'h00);
    endtask

    task automatic open_chunk();
        seq_chunk = 9'(bytes_in_chunk(chunk_size, seq_left, seq_addr));
        put_wren();
        put(snfc_pkg::ACT_SEL, 8'h00);
        put(snfc_pkg::ACT_SEND, snfc_pkg::CMD_PROGRAM);
        put_addr(seq_addr);
        seq_ph = snfc_pkg::PH_PG_DATA;
    endtask

    // Advance the sequencer state by one accepted word and queue what it yields.
    task automatic sequence_word(word_t w);
        int first;
        first = bus_expect.size();
        if (w.op <= snfc_pkg::OP_CHIP) begin
            if (seq_ph != snfc_pkg::PH_IDLE) put(snfc_pkg::ACT_REJECT, 8'h00);
            else begin
                seq_req = w.op;
                seq_addr = w.addr;
                case (w.op)
                    snfc_pkg::OP_READ_ID: begin
                        seq_ids = '0;
                        put(snfc_pkg::ACT_SEL, 8'h00);
                        put(snfc_pkg::ACT_SEND, snfc_pkg::CMD_READ_ID);
                        put(snfc_pkg::ACT_RECV, 8'h00);
                        seq_ph = snfc_pkg::PH_ID_RX;
                    end
                    snfc_pkg::OP_READ: begin
                        seq_left = w.len;
                        put(snfc_pkg::ACT_SEL, 8'h00);
                        put(snfc_pkg::ACT_SEND, snfc_pkg::CMD_READ);
                        put_addr(seq_addr);
                        if (w.len == 0) begin
                            put(snfc_pkg::ACT_DESEL, 8'h00);
                            put(snfc_pkg::ACT_DONE, 8'h00);
                        end else begin
                            put(snfc_pkg::ACT_RECV, 8'h00);
                            seq_ph = snfc_pkg::PH_RD_RX;
                        end
                    end
                    snfc_pkg::OP_PROGRAM: begin
                        seq_left = w.len;
                        if (w.len == 0) put(snfc_pkg::ACT_DONE, 8'h00);
                        else open_chunk();
                    end
                    default: begin
                        put_wren();
                        put_poll();
                        seq_ph = snfc_pkg::PH_ER_PRE;
                    end
                endcase
            end
        end else if (w.op == snfc_pkg::OP_DATA) begin
            if (seq_ph == snfc_pkg::PH_PG_DATA) begin
                put(snfc_pkg::ACT_SEND, w.b);
                seq_addr = seq_addr + 24'd1;
                seq_left = seq_left - 16'd1;
                seq_chunk = seq_chunk - 9'd1;
                if (seq_chunk == 0) begin
                    put(snfc_pkg::ACT_DESEL, 8'h00);
                    put_poll();
                    seq_ph = snfc_pkg::PH_PG_POLL;
                end
            end else put(snfc_pkg::ACT_REJECT, 8'h00);
        end else if (w.op == snfc_pkg::OP_REPLY) begin
            case (seq_ph)
                snfc_pkg::PH_ID_RX, snfc_pkg::PH_RD_RX: begin
                    put(snfc_pkg::ACT_HOST, w.b);
                    seq_ids = seq_ids + 2'd1;
                    if (seq_ph == snfc_pkg::PH_RD_RX) seq_left = seq_left - 16'd1;
                    if ((seq_ph == snfc_pkg::PH_ID_RX && seq_ids >= snfc_pkg::ID_BYTES_DEF)
                        || (seq_ph == snfc_pkg::PH_RD_RX && seq_left == 0)) begin
                        put(snfc_pkg::ACT_DESEL, 8'h00);
                        put(snfc_pkg::ACT_DONE, 8'h00);
                        seq_ph = snfc_pkg::PH_IDLE;
                    end else put(snfc_pkg::ACT_RECV, 8'h00);
                end
                snfc_pkg::PH_ER_PRE, snfc_pkg::PH_ER_POST, snfc_pkg::PH_PG_POLL: begin
                    if (w.b[0]) put(snfc_pkg::ACT_RECV, 8'h00);
                    else begin
                        put(snfc_pkg::ACT_DESEL, 8'h00);
                        if (seq_ph == snfc_pkg::PH_ER_PRE) begin
                            put(snfc_pkg::ACT_SEL, 8'h00);
                            if (seq_req == snfc_pkg::OP_SECTOR) begin
                                put(snfc_pkg::ACT_SEND, snfc_pkg::CMD_SECTOR);
                                put_addr(seq_addr);
                            end else put(snfc_pkg::ACT_SEND, snfc_pkg::CMD_CHIP);
                            put(snfc_pkg::ACT_DESEL, 8'h00);
                            put_poll();
                            seq_ph = snfc_pkg::PH_ER_POST;
                        end else if (seq_ph == snfc_pkg::PH_ER_POST || seq_left == 0) begin
                            put(snfc_pkg::ACT_DONE, 8'h00);
                            seq_ph = snfc_pkg::PH_IDLE;
                        end else open_chunk();
                    end
                end
                default: put(snfc_pkg::ACT_REJECT, 8'h00);
            endcase
        end else put(snfc_pkg::ACT_REJECT, 8'h00);
        if (bus_expect.size() > first) bus_expect[bus_expect.size()-1].last = 1'b1;
    endtask

    // Driver: hold the offered word until taken, otherwise offer the next one or idle.
    always @(posedge clk) begin
        logic nxt;
        word_t w;
        if (rst_n) begin
            nxt = push;
            if (push && !full) begin
                sequence_word(offered);
                words_taken++;
                nxt = 1'b0;
            end
            if (!nxt && pending.size() > 0
                && ((words_taken > 150 && words_taken < 230) || $urandom_range(99) >= 31)) begin
                w = pending.pop_front();
                offered   <= w;
                operation <= w.op;
                address   <= w.addr;
                length    <= w.len;
                data_byte <= w.b;
                nxt = 1'b1;
            end
            push <= nxt;
        end
    end

    // Monitor: check each popped result, stall at random, and hold off once for long.
    always @(posedge clk) begin
        snfc_pkg::step_t e;
        if (rst_n) begin
            if (pop && !empty) begin
                results_taken++;
                if (bus_expect.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: action %0d byte %02h last %0d",
                             $time, action, byte_value, last);
                end else begin
                    e = bus_expect.pop_front();
                    if (action !== e.action) begin
                        errors++;
                        $display("%0t: action expected %0d actual %0d", $time, e.action, action);
                    end
                    if (byte_value !== e.value) begin
                        errors++;
                        $display("%0t: byte expected %02h actual %02h", $time, e.value,
                                 byte_value);
                    end
                    if (last !== e.last) begin
                        errors++;
                        $display("%0t: last expected %0d actual %0d", $time, e.last, last);
                    end
                end
            end
            if (!hold_done && results_taken >= 300) begin
                hold_done <= 1'b1;
                hold_left <= 250;
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= (results_taken > 450 && results_taken < 650)
                       || ($urandom_range(99) >= 31);
            end
        end
    end

    // Watchdog: end the run if nothing moves while work is outstanding.
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty)) stale <= 0;
        else if (push || bus_expect.size() > 0) stale <= stale + 1;
        if (stale >= STALE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add(logic [2:0] op, logic [23:0] a, logic [15:0] l, logic [7:0] b);
        word_t w;
        w.op = op;
        w.addr = a;
        w.len = l;
        w.b = b;
        pending.push_back(w);
        phase_words++;
    endtask

    // Drop in a word that the block must reject while a sequence is under way.
    task automatic noise_busy();
        if ($urandom_range(99) < 8) begin
            if ($urandom_range(3) == 0)
                add(OP_UNUSED, 24'($urandom), 16'($urandom), 8'($urandom));
            else add(3'($urandom_range(4)), 24'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic poll_replies();
        int n;
        n = $urandom_range(3) == 0 ? $urandom_range(3) : 0;
        repeat (n) begin
            add(snfc_pkg::OP_REPLY, 24'($urandom), 16'($urandom),
                8'($urandom) | snfc_pkg::BUSY_MASK);
            noise_busy();
        end
        add(snfc_pkg::OP_REPLY, 24'($urandom), 16'($urandom),
            8'($urandom) & ~snfc_pkg::BUSY_MASK);
    endtask

    task automatic read_seq(logic [2:0] op, logic [23:0] a, int n);
        add(op, a, 16'(n), 8'($urandom));
        for (int i = 0; i < n; i++) begin
            noise_busy();
            add(snfc_pkg::OP_REPLY, 24'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic erase_seq(logic [2:0] op, logic [23:0] a);
        add(op, a, 16'($urandom), 8'($urandom));
        noise_busy();
        poll_replies();
        noise_busy();
        poll_replies();
    endtask

    task automatic program_seq(logic [23:0] a, int n);
        int c;
        logic [15:0] left;
        add(snfc_pkg::OP_PROGRAM, a, 16'(n), 8'($urandom));
        left = 16'(n);
        while (left > 0) begin
            c = bytes_in_chunk(chunk_size, left, a);
            repeat (c) begin
                noise_busy();
                add(snfc_pkg::OP_DATA, 24'($urandom), 16'($urandom), 8'($urandom));
            end
            noise_busy();
            poll_replies();
            left = left - 16'(c);
            a = a + 24'(c);
        end
    endtask

    function automatic logic [23:0] pick_addr();
        case ($urandom_range(2))
            0: return 24'($urandom);
            1: return {16'($urandom_range(16'hFFFF)), 8'($urandom_range(255, 240))};
            default: return 24'(24'hFFFFFF - $urandom_range(20));
        endcase
    endfunction

    task automatic run_random(int target);
        int k;
        phase_words = 0;
        while (phase_words < target) begin
            k = $urandom_range(99);
            if (k < 25) read_seq(snfc_pkg::OP_READ, pick_addr(), $urandom_range(12));
            else if (k < 55) program_seq(pick_addr(), $urandom_range(24));
            else if (k < 70) erase_seq(snfc_pkg::OP_SECTOR, pick_addr());
            else if (k < 75) erase_seq(snfc_pkg::OP_CHIP, pick_addr());
            else if (k < 85) read_seq(snfc_pkg::OP_READ_ID, 24'($urandom), 3);
            else add(3'($urandom_range(7, 5)), 24'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    // Wait until nothing is queued or expected, then let the block settle.
    task automatic drain();
        while (pending.size() > 0 || push || bus_expect.size() > 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_chunk(logic [8:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        chunk_size = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every request, idle rejects, extremes, page crossing and wrap.
        read_seq(snfc_pkg::OP_READ_ID, 24'h000000, 3);
        add(snfc_pkg::OP_READ, 24'hFFFFFF, 16'h0000, 8'h00);
        add(snfc_pkg::OP_READ, 24'h000000, 16'd2, 8'h00);
        add(snfc_pkg::OP_CHIP, 24'hFFFFFF, 16'hFFFF, 8'hFF);
        add(snfc_pkg::OP_REPLY, 24'h0, 16'h0, 8'hFF);
        add(snfc_pkg::OP_REPLY, 24'h0, 16'h0, 8'h00);
        add(snfc_pkg::OP_PROGRAM, 24'h0, 16'h0, 8'h00);
        program_seq(24'hFFFFFE, 3);
        erase_seq(snfc_pkg::OP_SECTOR, 24'hABCDEF);
        erase_seq(snfc_pkg::OP_CHIP, 24'h000000);
        add(snfc_pkg::OP_DATA, 24'hFFFFFF, 16'hFFFF, 8'hFF);
        add(snfc_pkg::OP_REPLY, 24'h0, 16'h0, 8'h5A);
        add(OP_UNUSED, 24'h0, 16'h0, 8'h00);
        drain();

        // Random phases, each at its own chunk size.
        set_chunk(9'd1);
        run_random(70);
        drain();
        set_chunk(9'd256);
        run_random(70);
        drain();
        set_chunk(9'd0);
        run_random(60);
        drain();
        set_chunk(9'd511);
        program_seq(24'h0000F0, 40);
        run_random(30);
        drain();
        set_chunk(9'($urandom_range(255, 2)));
        run_random(70);
        drain();
        set_chunk(9'd3);
        run_random(70);
        drain();

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/snfc_pkg.sv
hdl/snfc_front.sv
hdl/snfc_fifo.sv
hdl/snfc_back.sv
hdl/spi_nor_flash_command_sequencer_core.sv
verif/testbench.sv
